// ===== hw/rtl/lse_pkg.sv =====
// Shared types and codes for the LRU store with expiry.
`default_nettype none
package lse_pkg;

   // Operation codes carried by an input item
   typedef enum logic [2:0] {
      KIND_GET      = 3'd0,
      KIND_PUT      = 3'd1,
      KIND_REMOVE   = 3'd2,
      KIND_CONTAINS = 3'd3,
      KIND_TICK     = 3'd4,
      KIND_PURGE    = 3'd5,
      KIND_CLEAR    = 3'd6
   } kind_type;

   // Result status codes
   localparam logic [2:0] RSP_HIT       = 3'd0;
   localparam logic [2:0] RSP_ABSENT    = 3'd1;
   localparam logic [2:0] RSP_EXPIRED   = 3'd2;
   localparam logic [2:0] RSP_INSERTED  = 3'd3;
   localparam logic [2:0] RSP_UPDATED   = 3'd4;
   localparam logic [2:0] RSP_NOT_FOUND = 3'd5;

   // Configuration register indexes
   localparam logic CSR_DEFAULT_TTL    = 1'b0;
   localparam logic CSR_CAPACITY_LIMIT = 1'b1;

   localparam logic [4:0] CAP_LIMIT_RESET = 5'd16;

   // Datapath actions issued by the controller
   typedef enum logic [3:0] {
      EX_NONE,
      EX_NOP,
      EX_MISS,
      EX_GET_HIT,
      EX_DROP_EXPIRED,
      EX_CONTAINS_EXPIRED,
      EX_PUT_UPDATE,
      EX_PUT_INSERT,
      EX_REMOVE,
      EX_REMOVE_MISS,
      EX_TICK,
      EX_CLEAR,
      EX_PURGE
   } exec_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC,
      S_PURGE,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic        load_req;
      logic        lookup;
      exec_op_type op;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       hit;
      logic       hit_expired;
      logic       purge_last;
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lse_ctrl.sv =====
// Controller state machine for the LRU store with expiry.
`default_nettype none
module lse_ctrl
   import lse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;
   exec_op_type    exec_op;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // action for the looked-up item
   always_comb begin
      exec_op = EX_NOP;
      unique case (sts.kind)
         KIND_GET: begin
            if (!sts.hit)            exec_op = EX_MISS;
            else if (sts.hit_expired) exec_op = EX_DROP_EXPIRED;
            else                     exec_op = EX_GET_HIT;
         end
         KIND_PUT:    exec_op = sts.hit ? EX_PUT_UPDATE : EX_PUT_INSERT;
         KIND_REMOVE: exec_op = sts.hit ? EX_REMOVE : EX_REMOVE_MISS;
         KIND_CONTAINS: begin
            if (!sts.hit)            exec_op = EX_MISS;
            else if (sts.hit_expired) exec_op = EX_CONTAINS_EXPIRED;
            else                     exec_op = EX_NOP;
         end
         KIND_TICK:  exec_op = EX_TICK;
         KIND_CLEAR: exec_op = EX_CLEAR;
         default:    exec_op = EX_NOP;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_EXEC;
         S_EXEC:   state_in = (sts.kind == KIND_PURGE) ? S_PURGE : S_FINISH;
         S_PURGE:  if (sts.purge_last) state_in = S_FINISH;
         S_FINISH: if (rsp_free) state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = EX_NONE;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         S_LOOKUP: cmd.lookup = 1'b1;
         S_EXEC:   cmd.op = exec_op;
         S_PURGE:  cmd.op = EX_PURGE;
         S_FINISH: begin
            cmd.load_rsp = rsp_free;
            if (rsp_free) rsp_valid_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lse_dp.sv =====
// Datapath: entry cells, recency ranks, value memory and result registers.
`default_nettype none
module lse_dp
   import lse_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            cmd,
   output dp_sts_type                 sts,
   input  wire logic [15:0]           default_ttl,
   input  wire logic [4:0]            capacity_limit,
   input  wire logic [2:0]            req_kind,
   input  wire logic [KEY_BITS-1:0]   req_lookup_key,
   input  wire logic [VALUE_BITS-1:0] req_write_value,
   input  wire logic [15:0]           req_ttl_seconds,
   output logic [2:0]                 rsp_status,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   output logic                       rsp_evicted,
   output logic [4:0]                 rsp_purged_count,
   output logic [4:0]                 rsp_occupancy
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   // latched request
   logic [2:0]            kind_ff;
   logic [KEY_BITS-1:0]   key_req_ff;
   logic [VALUE_BITS-1:0] val_req_ff;
   logic [15:0]           ttl_req_ff;

   // entry cells
   logic [CAPACITY-1:0]   valid_ff;
   logic [KEY_BITS-1:0]   key_ff    [CAPACITY];
   logic [31:0]           expiry_ff [CAPACITY];
   logic [CAPACITY-1:0]   has_exp_ff;
   logic [IDX_W-1:0]      rank_ff   [CAPACITY];
   logic [31:0]           time_ff;
   logic [CNT_W-1:0]      count_ff;

   // value memory
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];
   logic [VALUE_BITS-1:0] rd_data_ff;

   // lookup results
   logic [CAPACITY-1:0]   hit_oh_ff, lru_oh_ff, free_oh_ff;
   logic                  hit_exp_ff, full_ff;

   // purge sweep and result staging
   logic [IDX_W-1:0]      purge_idx_ff;
   logic [CNT_W-1:0]      purged_ff;
   logic [2:0]            res_status_ff;
   logic                  res_evicted_ff, res_get_hit_ff;

   logic [2:0]            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_evicted_ff;
   logic [4:0]            rsp_purged_ff, rsp_occ_ff;

   logic [CAPACITY-1:0]   match_vec, expired_vec, lru_vec, free_vec;
   logic                  full, free_found;
   logic [IDX_W-1:0]      hit_idx, free_idx, hit_rank, last_rank;
   logic [15:0]           eff_ttl;
   logic [32:0]           exp_sum;
   logic [31:0]           exp_time;
   logic                  purge_hit;
   logic [IDX_W-1:0]      purge_rank;

   assign last_rank = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i]   = valid_ff[i] && (key_ff[i] == key_req_ff);
         expired_vec[i] = has_exp_ff[i] && (time_ff >= expiry_ff[i]);
         lru_vec[i]     = valid_ff[i] && (rank_ff[i] == last_rank);
      end
   end

   // store full against the effective limit (0 acts as 1, clipped to CAPACITY)
   assign full = ((CMP_W'(count_ff) >= CMP_W'(capacity_limit)) && (count_ff != '0))
              || (count_ff == CNT_W'(CAPACITY));

   // lowest free slot, counting the slot an eviction would free
   always_comb begin
      free_vec   = '0;
      free_found = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (!free_found && (!valid_ff[i] || (full && lru_vec[i]))) begin
            free_vec[i] = 1'b1;
            free_found  = 1'b1;
         end
      end
   end

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      hit_rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_oh_ff[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (free_oh_ff[i]) free_idx = free_idx | IDX_W'(i);
      end
   end

   assign eff_ttl  = (ttl_req_ff != 16'd0) ? ttl_req_ff : default_ttl;
   assign exp_sum  = {1'b0, time_ff} + 33'(eff_ttl);
   assign exp_time = exp_sum[32] ? '1 : exp_sum[31:0];

   assign purge_hit  = valid_ff[purge_idx_ff] && expired_vec[purge_idx_ff];
   assign purge_rank = rank_ff[purge_idx_ff];

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff    <= req_kind;
         key_req_ff <= req_lookup_key;
         val_req_ff <= req_write_value;
         ttl_req_ff <= req_ttl_seconds;
      end
      if (cmd.lookup) begin
         lru_oh_ff  <= lru_vec;
         free_oh_ff <= free_vec;
         full_ff    <= full;
      end
   end

   // control state: valid bits, time, count, sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         time_ff      <= '0;
         count_ff     <= '0;
         hit_oh_ff    <= '0;
         hit_exp_ff   <= 1'b0;
         purge_idx_ff <= '0;
         purged_ff    <= '0;
      end else begin
         if (cmd.load_req) begin
            purge_idx_ff <= '0;
            purged_ff    <= '0;
         end
         if (cmd.lookup) begin
            hit_oh_ff  <= match_vec;
            hit_exp_ff <= |(match_vec & expired_vec);
         end
         unique case (cmd.op)
            EX_DROP_EXPIRED, EX_REMOVE: begin
               valid_ff <= valid_ff & ~hit_oh_ff;
               count_ff <= count_ff - CNT_W'(1);
            end
            EX_PUT_INSERT: begin
               valid_ff <= (valid_ff & ~(full_ff ? lru_oh_ff : '0)) | free_oh_ff;
               if (!full_ff) count_ff <= count_ff + CNT_W'(1);
            end
            EX_TICK: if (time_ff != '1) time_ff <= time_ff + 32'd1;
            EX_CLEAR: begin
               valid_ff <= '0;
               count_ff <= '0;
            end
            EX_PURGE: begin
               purge_idx_ff <= purge_idx_ff + IDX_W'(1);
               if (purge_hit) begin
                  valid_ff[purge_idx_ff] <= 1'b0;
                  count_ff  <= count_ff - CNT_W'(1);
                  purged_ff <= purged_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // entry payload and recency ranks
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         unique case (cmd.op)
            EX_GET_HIT, EX_PUT_UPDATE: begin
               if (hit_oh_ff[i]) rank_ff[i] <= '0;
               else if (valid_ff[i] && rank_ff[i] < hit_rank)
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               if (cmd.op == EX_PUT_UPDATE && hit_oh_ff[i]) begin
                  expiry_ff[i]  <= (eff_ttl != 16'd0) ? exp_time : 32'd0;
                  has_exp_ff[i] <= eff_ttl != 16'd0;
               end
            end
            EX_DROP_EXPIRED, EX_REMOVE: begin
               if (!hit_oh_ff[i] && valid_ff[i] && rank_ff[i] > hit_rank)
                  rank_ff[i] <= rank_ff[i] - IDX_W'(1);
            end
            EX_PUT_INSERT: begin
               if (free_oh_ff[i]) begin
                  rank_ff[i]    <= '0;
                  key_ff[i]     <= key_req_ff;
                  expiry_ff[i]  <= (eff_ttl != 16'd0) ? exp_time : 32'd0;
                  has_exp_ff[i] <= eff_ttl != 16'd0;
               end else if (valid_ff[i] && !(full_ff && lru_oh_ff[i])) begin
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               end
            end
            EX_PURGE: begin
               if (purge_hit && IDX_W'(i) != purge_idx_ff && valid_ff[i]
                   && rank_ff[i] > purge_rank)
                  rank_ff[i] <= rank_ff[i] - IDX_W'(1);
            end
            default: ;
         endcase
      end
   end

   // value memory: one write or one read per item
   always_ff @(posedge clock) begin
      if (cmd.op == EX_PUT_UPDATE) val_mem[hit_idx] <= val_req_ff;
      if (cmd.op == EX_PUT_INSERT) val_mem[free_idx] <= val_req_ff;
      if (cmd.op == EX_GET_HIT) rd_data_ff <= val_mem[hit_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.op != EX_NONE) begin
         res_evicted_ff <= (cmd.op == EX_PUT_INSERT) && full_ff;
         res_get_hit_ff <= cmd.op == EX_GET_HIT;
         unique case (cmd.op)
            EX_MISS:                              res_status_ff <= RSP_ABSENT;
            EX_DROP_EXPIRED, EX_CONTAINS_EXPIRED: res_status_ff <= RSP_EXPIRED;
            EX_PUT_UPDATE:                        res_status_ff <= RSP_UPDATED;
            EX_PUT_INSERT:                        res_status_ff <= RSP_INSERTED;
            EX_REMOVE_MISS:                       res_status_ff <= RSP_NOT_FOUND;
            default:                              res_status_ff <= RSP_HIT;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_status_ff  <= res_status_ff;
         rsp_value_ff   <= res_get_hit_ff ? rd_data_ff : '0;
         rsp_evicted_ff <= res_evicted_ff;
         rsp_purged_ff  <= 5'(purged_ff);
         rsp_occ_ff     <= 5'(count_ff);
      end
   end

   assign sts.kind        = kind_ff;
   assign sts.hit         = |hit_oh_ff;
   assign sts.hit_expired = hit_exp_ff;
   assign sts.purge_last  = purge_idx_ff == IDX_W'(CAPACITY - 1);

   assign rsp_status       = rsp_status_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_purged_count = rsp_purged_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lru_store_with_expiry.sv =====
// Top level of the LRU key/value store with per-entry expiry.
// Usage:
//  - Input channel req_*: one item per operation (get, put, remove, contains,
//    tick, purge expired, clear). Taken when req_valid is high and req_stall
//    low. req_stall is high while an item is being worked on.
//  - Result channel rsp_*: exactly one item per input item, taken when
//    rsp_valid is high and rsp_stall low. The result sits in an output
//    register, so the next item can be taken while it waits.
//  - csr_*: write-only registers; default ttl and capacity limit. Write only
//    while the store is idle.
// Steps:
//  - Ordinary operations: key lookup, update, result load; a new item is
//    taken only once the result of the last one has been loaded.
//  - Purge sweeps every slot once, one per cycle, after the update step and
//    before the result load; a new item again waits for the result load.
// Reset: synchronous; empties the store, time to zero, default ttl 0 and
//  capacity limit 16. No clearing pass is needed.
// Stall: a result held by rsp_stall stays put; the next item may be taken and
//  looked up, then waits in the final step until the output register frees.
`default_nettype none
module lru_store_with_expiry
   import lse_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_kind,
   input  wire logic [KEY_BITS-1:0]   req_lookup_key,
   input  wire logic [VALUE_BITS-1:0] req_write_value,
   input  wire logic [15:0]           req_ttl_seconds,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   output logic                       rsp_evicted,
   output logic [4:0]                 rsp_purged_count,
   output logic [4:0]                 rsp_occupancy,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_index,
   input  wire logic [15:0]           csr_write_data
);

   logic [15:0] default_ttl_ff;
   logic [4:0]  cap_limit_ff;
   dp_cmd_type  cmd;
   dp_sts_type  sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         default_ttl_ff <= 16'd0;
         cap_limit_ff   <= CAP_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEFAULT_TTL:    default_ttl_ff <= csr_write_data;
            CSR_CAPACITY_LIMIT: cap_limit_ff   <= csr_write_data[4:0];
         endcase
      end
   end

   lse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lse_dp #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .default_ttl      (default_ttl_ff),
      .capacity_limit   (cap_limit_ff),
      .req_kind         (req_kind),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .req_ttl_seconds  (req_ttl_seconds),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_purged_count (rsp_purged_count),
      .rsp_occupancy    (rsp_occupancy)
   );

   // an accepted item keeps the input closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on consecutive cycles");

   // eviction only goes with an insertion
   a_evict_on_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (rsp_status == RSP_INSERTED))
      else $error("eviction reported without insertion");

   // an expired hit needs a hit
   a_expired_is_hit: assert property (@(posedge clock) disable iff (reset)
      sts.hit_expired |-> sts.hit)
      else $error("expired flag without key match");

endmodule
`default_nettype wire

// ===== sim/lru_store_with_expiry_tb.sv =====
// Self-checking testbench for the LRU key/value store with per-entry expiry.
`default_nettype none
module lru_store_with_expiry_tb
   import lse_pkg::*;
();

   localparam int SLOTS = 16;
   localparam logic [31:0] TIME_TOP = 32'hFFFF_FFFF;
   localparam logic [2:0]  KIND_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] key;
      logic [63:0] value;
      logic [15:0] ttl;
   } op_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] value;
      logic        evicted;
      logic [4:0]  purged;
      logic [4:0]  occupancy;
   } op_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Stimulus side
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_lookup_key = '0;
   logic [63:0] req_write_value = '0;
   logic [15:0] req_ttl_seconds = '0;

   // Result side
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_read_value;
   logic        rsp_evicted;
   logic [4:0]  rsp_purged_count;
   logic [4:0]  rsp_occupancy;

   // Register port
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_write_data = '0;

   lru_store_with_expiry i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .req_ttl_seconds  (req_ttl_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_purged_count (rsp_purged_count),
      .rsp_occupancy    (rsp_occupancy),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the store, kept in step with every accepted item
   // ---------------------------------------------------------------------
   logic        sh_valid  [SLOTS];
   logic [31:0] sh_key    [SLOTS];
   logic [63:0] sh_value  [SLOTS];
   logic [31:0] sh_expiry [SLOTS];
   logic        sh_expires[SLOTS];
   int unsigned sh_rank   [SLOTS];
   logic [31:0] sh_now;
   int unsigned sh_count;
   logic [15:0] sh_default_ttl;
   logic [4:0]  sh_limit;

   op_item_type   pending_items[$];
   op_result_type expected_results[$];

   int  errors = 0;
   int  results_seen = 0;
   int  evictions_seen = 0;
   int  expired_seen = 0;

   // Idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
   int  idle_mode = 0;
   bit  hold_off = 1'b0;      // long receiver hold-off in progress
   bit  sender_pause = 1'b0;  // sender waits for the store to drain

   function automatic int find_key(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i] && sh_key[i] == k) return i;
      return -1;
   endfunction

   function automatic bit is_stale(int s);
      return sh_expires[s] && sh_now >= sh_expiry[s];
   endfunction

   function automatic void drop_entry(int s);
      int unsigned r;
      r = sh_rank[s];
      sh_valid[s] = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
      sh_count--;
   endfunction

   function automatic void promote(int s);
      int unsigned r;
      r = sh_rank[s];
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i] && i != s && sh_rank[i] < r) sh_rank[i]++;
      sh_rank[s] = 0;
   endfunction

   function automatic void empty_store();
      for (int i = 0; i < SLOTS; i++) begin
         sh_valid[i] = 1'b0;
         sh_rank[i] = 0;
      end
      sh_count = 0;
   endfunction

   // Work out the result of one operation and advance the shadow state
   function automatic op_result_type apply_operation(op_item_type it);
      op_result_type res;
      int            s;
      int            victim;
      logic [15:0]   eff;
      logic [31:0]   exp_at;
      int unsigned   lim;
      res = '0;
      case (it.kind)
         KIND_GET: begin
            s = find_key(it.key);
            if (s < 0) res.status = RSP_ABSENT;
            else if (is_stale(s)) begin
               drop_entry(s);
               res.status = RSP_EXPIRED;
            end else begin
               promote(s);
               res.status = RSP_HIT;
               res.value = sh_value[s];
            end
         end
         KIND_PUT: begin
            eff = (it.ttl != 0) ? it.ttl : sh_default_ttl;
            exp_at = ({16'd0, eff} > TIME_TOP - sh_now) ? TIME_TOP : sh_now + eff;
            lim = (sh_limit == 0) ? 1 : (sh_limit > SLOTS ? SLOTS : sh_limit);
            s = find_key(it.key);
            if (s >= 0) res.status = RSP_UPDATED;
            else begin
               if (sh_count >= lim) begin
                  victim = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (sh_valid[i] && (victim < 0 || sh_rank[i] > sh_rank[victim]))
                        victim = i;
                  if (victim >= 0) begin
                     drop_entry(victim);
                     res.evicted = 1'b1;
                  end
               end
               s = 0;
               while (s < SLOTS && sh_valid[s]) s++;
               for (int i = 0; i < SLOTS; i++)
                  if (sh_valid[i]) sh_rank[i]++;
               sh_valid[s] = 1'b1;
               sh_key[s] = it.key;
               sh_rank[s] = 0;
               sh_count++;
               res.status = RSP_INSERTED;
            end
            sh_value[s] = it.value;
            sh_expires[s] = (eff != 0);
            sh_expiry[s] = (eff != 0) ? exp_at : '0;
            promote(s);
         end
         KIND_REMOVE: begin
            s = find_key(it.key);
            if (s < 0) res.status = RSP_NOT_FOUND;
            else drop_entry(s);
         end
         KIND_CONTAINS: begin
            s = find_key(it.key);
            if (s < 0) res.status = RSP_ABSENT;
            else if (is_stale(s)) res.status = RSP_EXPIRED;
         end
         KIND_TICK: if (sh_now != TIME_TOP) sh_now++;
         KIND_PURGE: begin
            for (int i = 0; i < SLOTS; i++)
               if (sh_valid[i] && is_stale(i)) begin
                  drop_entry(i);
                  res.purged++;
               end
         end
         KIND_CLEAR: empty_store();
         default: ;
      endcase
      res.occupancy = sh_count[4:0];
      return res;
   endfunction

   // Append one item to the stimulus queue
   function automatic void add_item(op_item_type it);
      pending_items = {pending_items, it};
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued items; a held item never changes while stalled
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      op_item_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results = {expected_results, apply_operation(
               '{req_kind, req_lookup_key, req_write_value, req_ttl_seconds})};
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && !sender_pause &&
                !(idle_mode == 1 && $urandom_range(99) < 86) &&
                !(idle_mode == 3 && $urandom_range(99) < 7)) begin
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_kind <= nxt.kind;
               req_lookup_key <= nxt.key;
               req_write_value <= nxt.value;
               req_ttl_seconds <= nxt.ttl;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, random per mode, forced high during a hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (idle_mode == 2) rsp_stall <= ($urandom_range(99) < 86);
      else if (idle_mode == 3) rsp_stall <= ($urandom_range(99) < 7);
      else rsp_stall <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Monitor: compares every accepted result with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      op_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d occupancy=%0d",
                     $time, rsp_status, rsp_occupancy);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (want.evicted) evictions_seen++;
            if (want.status == RSP_EXPIRED) expired_seen++;
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_read_value !== want.value) begin
               $display("%0t: read_value expected %h actual %h",
                        $time, want.value, rsp_read_value);
               errors++;
            end
            if (rsp_evicted !== want.evicted) begin
               $display("%0t: evicted expected %0d actual %0d",
                        $time, want.evicted, rsp_evicted);
               errors++;
            end
            if (rsp_purged_count !== want.purged) begin
               $display("%0t: purged_count expected %0d actual %0d",
                        $time, want.purged, rsp_purged_count);
               errors++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, rsp_occupancy);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   logic [31:0] key_pool[8];

   function automatic op_item_type make_item(logic [2:0] k, logic [31:0] key,
                                             logic [63:0] v, logic [15:0] t);
      op_item_type it;
      it.kind = k;
      it.key = key;
      it.value = v;
      it.ttl = t;
      return it;
   endfunction

   // Mostly keys from a small pool so hits, updates and expiries happen
   function automatic op_item_type random_item();
      op_item_type it;
      int unsigned p;
      p = $urandom_range(99);
      it.key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom;
      it.value = {$urandom, $urandom};
      case ($urandom_range(3))
         0: it.ttl = 16'd0;
         1: it.ttl = 16'($urandom_range(1, 6));
         2: it.ttl = 16'($urandom_range(7, 40));
         default: it.ttl = 16'($urandom);
      endcase
      if (p < 28) it.kind = KIND_PUT;
      else if (p < 50) it.kind = KIND_GET;
      else if (p < 60) it.kind = KIND_REMOVE;
      else if (p < 70) it.kind = KIND_CONTAINS;
      else if (p < 92) it.kind = KIND_TICK;
      else if (p < 97) it.kind = KIND_PURGE;
      else if (p < 99) it.kind = KIND_CLEAR;
      else it.kind = KIND_UNUSED;
      return it;
   endfunction

   // Wait until every queued item is accepted and every result is back
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      // settle before the next phase
      repeat (SLOTS + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DEFAULT_TTL) sh_default_ttl = data;
      else sh_limit = data[4:0];
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) add_item(random_item());
      drain();
   endtask

   // Long receiver hold-off, counted here in cycles, while items keep coming
   task automatic long_hold_off();
      for (int i = 0; i < 20; i++) add_item(random_item());
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
      drain();
   endtask

   initial begin
      empty_store();
      sh_now = '0;
      sh_default_ttl = '0;
      sh_limit = CAP_LIMIT_RESET;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every operation, expiry corner cases
      add_item(make_item(KIND_GET, 32'h0, '0, '0));
      add_item(make_item(KIND_REMOVE, 32'h0, '0, '0));
      add_item(make_item(KIND_PUT, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2));
      add_item(make_item(KIND_PUT, 32'hFFFF_FFFF, 64'h0, 16'd0));
      add_item(make_item(KIND_PUT, 32'h5A5A_A5A5, 64'h1234, 16'hFFFF));
      add_item(make_item(KIND_GET, 32'h0, '0, '0));
      add_item(make_item(KIND_CONTAINS, 32'hFFFF_FFFF, '0, '0));
      add_item(make_item(KIND_TICK, '0, '0, '0));
      add_item(make_item(KIND_TICK, '0, '0, '0));
      add_item(make_item(KIND_CONTAINS, 32'h0, '0, '0));
      add_item(make_item(KIND_GET, 32'h0, '0, '0));
      add_item(make_item(KIND_PUT, 32'h1, 64'h77, 16'd1));
      add_item(make_item(KIND_TICK, '0, '0, '0));
      add_item(make_item(KIND_PUT, 32'h1, 64'h88, 16'd0));
      add_item(make_item(KIND_PUT, 32'h2, 64'h99, 16'd1));
      add_item(make_item(KIND_TICK, '0, '0, '0));
      add_item(make_item(KIND_REMOVE, 32'h2, '0, '0));
      add_item(make_item(KIND_PUT, 32'h3, 64'h5, 16'd1));
      add_item(make_item(KIND_TICK, '0, '0, '0));
      add_item(make_item(KIND_PURGE, '0, '0, '0));
      add_item(make_item(KIND_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
      add_item(make_item(KIND_CLEAR, '0, '0, '0));
      add_item(make_item(KIND_PURGE, '0, '0, '0));
      drain();

      // Small limit with default ttl: eviction on almost every new key
      write_reg(CSR_DEFAULT_TTL, 16'd3);
      write_reg(CSR_CAPACITY_LIMIT, 16'd1);
      random_phase(40);

      // Limit 0 behaves as 1; receiver stalls often
      idle_mode = 2;
      write_reg(CSR_CAPACITY_LIMIT, 16'd0);
      write_reg(CSR_DEFAULT_TTL, 16'hFFFF);
      random_phase(30);

      // Above the slot count, sender idles often; widen keys for a full store
      idle_mode = 1;
      write_reg(CSR_CAPACITY_LIMIT, 16'd31);
      write_reg(CSR_DEFAULT_TTL, 16'd0);
      for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
      random_phase(80);

      // Fill the store then lower the limit beneath the occupancy
      idle_mode = 0;
      for (int i = 0; i < 18; i++)
         add_item(make_item(KIND_PUT, 32'h100 + i, {$urandom, $urandom}, 16'd0));
      drain();
      write_reg(CSR_CAPACITY_LIMIT, 16'd4);
      write_reg(CSR_DEFAULT_TTL, 16'd5);
      random_phase(60);

      // Both sides idle now and then; mid-range settings
      idle_mode = 3;
      write_reg(CSR_CAPACITY_LIMIT, 16'd16);
      write_reg(CSR_DEFAULT_TTL, 16'd10);
      random_phase(60);

      // Long receiver hold-off with the sender still offering items
      idle_mode = 0;
      long_hold_off();

      // Sender pauses mid-stream until every result has arrived, then resumes
      for (int i = 0; i < 10; i++) add_item(random_item());
      while (pending_items.size() > 5) @(posedge clock);
      sender_pause = 1'b1;
      while (expected_results.size() != 0 || req_valid) @(posedge clock);
      sender_pause = 1'b0;
      drain();

      // Time saturation is out of reach by ticking; huge ttls do not reach it either
      write_reg(CSR_CAPACITY_LIMIT, 16'd8);
      random_phase(80);

      $display("tb: %0d results checked, %0d evictions, %0d expired misses",
               results_seen, evictions_seen, expired_seen);
      $display("tb: limits 0/1/4/8/16/31 and default ttl 0/3/5/10/65535, idle and stall mixes");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
